>>> sv/pbc_pkg.sv
// shared types, constants and bit-order helpers for the prbs byte checker
`default_nettype none

package pbc_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int CFG_ADDR_W  = 4;
    localparam int CFG_DATA_W  = 32;

    // register indexes, byte address is 4 * index
    localparam logic [1:0] REG_TAP_MASK        = 2'd0;
    localparam logic [1:0] REG_INVERT_FEEDBACK = 2'd1;
    localparam logic [1:0] REG_BREAK_LOCKUP    = 2'd2;
    localparam logic [1:0] REG_MSB_FIRST       = 2'd3;

    localparam logic [15:0] TAP_MASK_RESET = 16'd1280;

    typedef struct packed {
        logic [15:0] tap_mask;
        logic        invert_feedback;
        logic        break_lockup;
        logic        msb_first;
    } cfg_t;

    function automatic logic [7:0] flip8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[7 - i] = v[i];
        end
        return r;
    endfunction

    function automatic logic [15:0] flip_halves(input logic [15:0] w);
        return {flip8(w[15:8]), flip8(w[7:0])};
    endfunction

endpackage

`default_nettype wire

>>> sv/pbc_predict.sv
// next-byte prediction: eight lfsr steps plus lock-up break and bit-order handling
`default_nettype none

module pbc_predict (
    input  wire logic [15:0]  history_word,
    input  wire pbc_pkg::cfg_t cfg,
    output logic [7:0]        expected_byte
);
    import pbc_pkg::*;

    logic [15:0] lfsr;
    logic        fb;
    logic [15:0] span;
    logic [15:0] pattern;
    logic [7:0]  pred;

    always_comb
    begin
        lfsr = cfg.msb_first ? history_word : flip_halves(history_word);
        for (int i = 0; i < 8; i++)
        begin
            fb   = cfg.invert_feedback ^ (^(lfsr & cfg.tap_mask));
            lfsr = {lfsr[14:0], fb};
        end
        pred = lfsr[7:0];

        // all ones from the highest tap down to stage one
        span = cfg.tap_mask;
        span = span | (span >> 1);
        span = span | (span >> 2);
        span = span | (span >> 4);
        span = span | (span >> 8);
        if (!cfg.msb_first)
        begin
            span = flip_halves(span);
        end
        pattern = cfg.invert_feedback ? span : 16'h0000;

        if (cfg.break_lockup && ((history_word & span) == pattern))
        begin
            pred[0] = ~pred[0];
        end

        expected_byte = cfg.msb_first ? pred : flip8(pred);
    end

endmodule

`default_nettype wire

>>> sv/prbs_byte_checker_core.sv
// Byte-wide self-synchronizing PRBS checker. Each received word is predicted from the
// two bytes received before it (16-bit Fibonacci LFSR stepped eight times, taps from
// tap_mask, optional inverted feedback, LSB-first order and lock-up break), compared,
// and mismatches are counted in a saturating counter shown as error_total. Throughput
// is one word per clock while out_stall is low: a word is held in the input register,
// the prediction and compare are combinational logic into the result register, and
// out_valid is set when the word moves there. Configure only while the checker is idle.
`default_nettype none

module prbs_byte_checker_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [pbc_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [pbc_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic      [pbc_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                  pready,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [7:0]                       data_byte,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic      [7:0]                       expected_byte,
    output logic                                  mismatch,
    output logic      [31:0]                      error_total
);
    import pbc_pkg::*;

    cfg_t cfg_reg;

    logic                   s1_valid_reg;
    logic [7:0]             s1_data_reg;
    logic [7:0]             hist0_reg;
    logic [7:0]             hist1_reg;
    logic                   out_valid_reg;
    logic [7:0]             exp_reg;
    logic                   miss_reg;
    logic [COUNT_WIDTH-1:0] cnt_reg;
    logic [COUNT_WIDTH-1:0] cnt_next;

    logic       cfg_write;
    logic [1:0] reg_index;
    logic       advance;
    logic       in_accept;
    logic [7:0] pred_byte;
    logic       pred_miss;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tap_mask        <= TAP_MASK_RESET;
            cfg_reg.invert_feedback <= 1'b0;
            cfg_reg.break_lockup    <= 1'b0;
            cfg_reg.msb_first       <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                REG_TAP_MASK:        cfg_reg.tap_mask        <= pwdata[15:0];
                REG_INVERT_FEEDBACK: cfg_reg.invert_feedback <= pwdata[0];
                REG_BREAK_LOCKUP:    cfg_reg.break_lockup    <= pwdata[0];
                REG_MSB_FIRST:       cfg_reg.msb_first       <= pwdata[0];
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_TAP_MASK:        prdata = {16'h0000, cfg_reg.tap_mask};
            REG_INVERT_FEEDBACK: prdata = {31'd0, cfg_reg.invert_feedback};
            REG_BREAK_LOCKUP:    prdata = {31'd0, cfg_reg.break_lockup};
            REG_MSB_FIRST:       prdata = {31'd0, cfg_reg.msb_first};
            default:             prdata = '0;
        endcase
    end

    // word moves into the result register when that register is free or being taken
    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    pbc_predict u_predict (
        .history_word  ({hist1_reg, hist0_reg}),
        .cfg           (cfg_reg),
        .expected_byte (pred_byte)
    );

    assign pred_miss = (s1_data_reg != pred_byte);
    assign cnt_next  = (pred_miss && (cnt_reg != {COUNT_WIDTH{1'b1}}))
                       ? cnt_reg + COUNT_WIDTH'(1) : cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            hist0_reg     <= 8'h00;
            hist1_reg     <= 8'h00;
            cnt_reg       <= '0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                hist1_reg     <= hist0_reg;
                hist0_reg     <= s1_data_reg;
                cnt_reg       <= cnt_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_data_reg <= data_byte;
        end
        if (advance)
        begin
            exp_reg  <= pred_byte;
            miss_reg <= pred_miss;
        end
    end

    assign out_valid     = out_valid_reg;
    assign expected_byte = exp_reg;
    assign mismatch      = miss_reg;
    assign error_total   = 32'(cnt_reg);

endmodule

`default_nettype wire
